[src/ebcd_pkg.sv]
// Shared widths, types and codes of the energy burst command detector.
package ebcd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int ENERGY_W    = 26;
    localparam int FLEN_W      = 8;
    localparam int FTIME_W     = 10;
    localparam int TIMEOUT_W   = 16;
    localparam int QUIET_W     = 17;
    localparam int BURST_W     = 8;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [QUIET_W-1:0]  QUIET_MAX  = {QUIET_W{1'b1}};
    localparam logic [BURST_W-1:0]  BURST_MAX  = {BURST_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT  = 2'd3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_STAND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SIT      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORWARD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BACKWARD = 2'd3;

    typedef logic [ENERGY_W-1:0] energy_t;

    // Frame energy handed from the accumulator to the frame queue
    typedef struct packed {
        logic    valid;
        energy_t energy;
    } frame_evt_t;

    // Settings used by the burst state machine
    typedef struct packed {
        energy_t               threshold;
        logic [FTIME_W-1:0]    frame_time;
        logic [TIMEOUT_W-1:0]  gap_timeout;
    } back_cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BURST_W-1:0] burst_total;
    } result_t;

endpackage

[src/ebcd_front.sv]
// Front end: center and square each sample, then sum squares into frame energies.
module ebcd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [ebcd_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [ebcd_pkg::FLEN_W-1:0]    frame_length,
    input  logic                           fq_full,
    output ebcd_pkg::frame_evt_t           frame_evt
);

    localparam logic [ebcd_pkg::SAMPLE_BITS-1:0] MID =
        {1'b1, {(ebcd_pkg::SAMPLE_BITS-1){1'b0}}};

    logic                          sq_valid_reg, sq_valid_next;
    logic [ebcd_pkg::SQ_W-1:0]     sq_reg;
    logic [ebcd_pkg::SAMPLE_BITS-1:0] offset;
    logic [ebcd_pkg::SQ_W-1:0]     sq_now;
    logic                          accept, acc_go;

    logic [ebcd_pkg::FLEN_W-1:0]   idx_reg, idx_next, idx_inc;
    ebcd_pkg::energy_t             energy_reg, energy_next, energy_sat;
    logic [ebcd_pkg::ENERGY_W:0]   energy_wide;
    logic                          frame_end;

    assign accept = push && !full;
    assign acc_go = sq_valid_reg && !fq_full;
    assign full   = sq_valid_reg && fq_full;

    // Stage 1: distance from midpoint and its square
    always_comb
    begin
        offset = (sample >= MID) ? (sample - MID) : (MID - sample);
        sq_now = ebcd_pkg::SQ_W'(offset) * ebcd_pkg::SQ_W'(offset);
    end

    always_comb
    begin
        sq_valid_next = sq_valid_reg;
        if (accept)
        begin
            sq_valid_next = 1'b1;
        end
        else if (acc_go)
        begin
            sq_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg <= sq_now;
        end
    end

    // Stage 2: saturating accumulate and frame boundary
    always_comb
    begin
        energy_wide = {1'b0, energy_reg}
                    + (ebcd_pkg::ENERGY_W+1)'(sq_reg);
        energy_sat  = energy_wide[ebcd_pkg::ENERGY_W] ? ebcd_pkg::ENERGY_MAX
                    : energy_wide[ebcd_pkg::ENERGY_W-1:0];
        idx_inc     = idx_reg + 1'b1;
        frame_end   = (idx_inc == '0) || (idx_inc >= frame_length);

        idx_next    = idx_reg;
        energy_next = energy_reg;
        if (acc_go)
        begin
            if (frame_end)
            begin
                idx_next    = '0;
                energy_next = '0;
            end
            else
            begin
                idx_next    = idx_inc;
                energy_next = energy_sat;
            end
        end

        frame_evt.valid  = acc_go && frame_end;
        frame_evt.energy = energy_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            idx_reg      <= '0;
            energy_reg   <= '0;
        end
        else
        begin
            sq_valid_reg <= sq_valid_next;
            idx_reg      <= idx_next;
            energy_reg   <= energy_next;
        end
    end

endmodule

[src/ebcd_frame_q.sv]
// Four-entry queue of frame energies between the front and back ends.
module ebcd_frame_q (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ebcd_pkg::frame_evt_t  in_evt,
    output logic                  q_full,
    input  logic                  q_pop,
    output ebcd_pkg::frame_evt_t  out_evt
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    ebcd_pkg::energy_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;
    logic                   do_push, do_pop;

    assign q_full         = (count_reg == (PTR_W+1)'(DEPTH));
    assign out_evt.valid  = (count_reg != '0);
    assign out_evt.energy = mem_reg[rd_ptr_reg];

    assign do_push = in_evt.valid && !q_full;
    assign do_pop  = q_pop && out_evt.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_evt.energy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/ebcd_back.sv]
// Back end: idle/active/gap burst machine and the two-entry result queue.
module ebcd_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ebcd_pkg::frame_evt_t           frame_evt,
    output logic                           frame_pop,
    input  ebcd_pkg::back_cfg_t            cfg,
    output logic                           empty,
    input  logic                           pop,
    output logic [ebcd_pkg::CMD_W-1:0]     command,
    output logic [ebcd_pkg::BURST_W-1:0]   burst_total
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ACTIVE = 2'd1;
    localparam logic [1:0] PH_GAP    = 2'd2;

    logic [1:0]                     phase_reg, phase_next;
    logic [ebcd_pkg::BURST_W-1:0]   bursts_reg, bursts_next;
    logic [ebcd_pkg::QUIET_W-1:0]   quiet_reg, quiet_next, quiet_sat;
    logic [ebcd_pkg::QUIET_W:0]     quiet_wide;
    logic                           loud, go, emit;
    ebcd_pkg::result_t              res_now;

    ebcd_pkg::result_t              oq_reg [2];
    logic                           oq_wr_reg, oq_wr_next;
    logic                           oq_rd_reg, oq_rd_next;
    logic [1:0]                     oq_count_reg, oq_count_next;
    logic                           oq_push, oq_pop;

    // Advance one frame whenever a frame is waiting and a result slot is free
    assign go        = frame_evt.valid && (oq_count_reg != 2'd2);
    assign frame_pop = go;
    assign loud      = frame_evt.energy > cfg.threshold;

    always_comb
    begin
        quiet_wide = {1'b0, quiet_reg} + (ebcd_pkg::QUIET_W+1)'(cfg.frame_time);
        quiet_sat  = quiet_wide[ebcd_pkg::QUIET_W] ? ebcd_pkg::QUIET_MAX
                   : quiet_wide[ebcd_pkg::QUIET_W-1:0];

        phase_next  = phase_reg;
        bursts_next = bursts_reg;
        quiet_next  = quiet_reg;
        emit        = 1'b0;

        priority if (bursts_reg >= ebcd_pkg::BURST_W'(4))
        begin
            res_now.command = ebcd_pkg::CMD_BACKWARD;
        end
        else
        begin
            res_now.command = ebcd_pkg::CMD_W'(bursts_reg - 1'b1);
        end
        res_now.burst_total = bursts_reg;

        if (go)
        begin
            unique case (phase_reg)
                PH_ACTIVE:
                begin
                    if (!loud)
                    begin
                        quiet_next = ebcd_pkg::QUIET_W'(cfg.frame_time);
                        phase_next = PH_GAP;
                    end
                end
                PH_GAP:
                begin
                    if (loud)
                    begin
                        if (bursts_reg != ebcd_pkg::BURST_MAX)
                        begin
                            bursts_next = bursts_reg + 1'b1;
                        end
                        phase_next = PH_ACTIVE;
                    end
                    else
                    begin
                        quiet_next = quiet_sat;
                        if (quiet_sat >= ebcd_pkg::QUIET_W'(cfg.gap_timeout))
                        begin
                            emit        = (bursts_reg != '0);
                            bursts_next = '0;
                            quiet_next  = '0;
                            phase_next  = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    // Idle, and the unused code that falls back to idle
                    phase_next = PH_IDLE;
                    if (loud)
                    begin
                        bursts_next = ebcd_pkg::BURST_W'(1);
                        quiet_next  = '0;
                        phase_next  = PH_ACTIVE;
                    end
                end
            endcase
        end
    end

    // Result queue
    assign oq_push     = go && emit;
    assign empty       = (oq_count_reg == 2'd0);
    assign oq_pop      = pop && !empty;
    assign command     = oq_reg[oq_rd_reg].command;
    assign burst_total = oq_reg[oq_rd_reg].burst_total;

    always_comb
    begin
        oq_wr_next    = oq_push ? !oq_wr_reg : oq_wr_reg;
        oq_rd_next    = oq_pop  ? !oq_rd_reg : oq_rd_reg;
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (oq_pop && !oq_push)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= res_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            bursts_reg   <= '0;
            quiet_reg    <= '0;
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            bursts_reg   <= bursts_next;
            quiet_reg    <= quiet_next;
            oq_wr_reg    <= oq_wr_next;
            oq_rd_reg    <= oq_rd_next;
            oq_count_reg <= oq_count_next;
        end
    end

endmodule

[src/energy_burst_command_detector.sv]
// Top level of the energy burst command detector: configuration registers and wiring.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -----------------------------------
//  samples   push / full               sample [9:0]
//  results   empty / pop               command [1:0], burst_total [7:0]
//  config    cfg_valid / cfg_ready     cfg_index [1:0], cfg_data [25:0]
//
// One sample is taken every cycle while full is low. A sample is registered
// in the squarer and summed into the running energy; a frame energy then waits
// in a four-entry queue and the burst machine takes one frame per cycle while
// the result queue has room, so a decided result passes the squarer register,
// the frame queue and the result queue before it is on the result ports.
// Reset clears the frame count, running energy, burst machine and both queues;
// registers return to threshold 2000000, frame length 64, frame time 20 ms and
// gap timeout 400 ms. full rises only when the frame queue fills, which
// happens when the result queue (two entries) is not drained.
module energy_burst_command_detector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample queue side
    input  logic                                 push,
    output logic                                 full,
    input  logic [ebcd_pkg::SAMPLE_BITS-1:0]     sample,
    // result queue side
    output logic                                 empty,
    input  logic                                 pop,
    output logic [ebcd_pkg::CMD_W-1:0]           command,
    output logic [ebcd_pkg::BURST_W-1:0]         burst_total,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ebcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ebcd_pkg::ENERGY_W-1:0]        cfg_data
);

    ebcd_pkg::energy_t                 threshold_reg, threshold_next;
    logic [ebcd_pkg::FLEN_W-1:0]       frame_length_reg, frame_length_next;
    logic [ebcd_pkg::FTIME_W-1:0]      frame_time_reg, frame_time_next;
    logic [ebcd_pkg::TIMEOUT_W-1:0]    gap_timeout_reg, gap_timeout_next;

    ebcd_pkg::frame_evt_t              acc_evt;
    ebcd_pkg::frame_evt_t              q_evt;
    ebcd_pkg::back_cfg_t               back_cfg;
    logic                              fq_full;
    logic                              fq_pop;

    // Register writes are always taken; each value is trimmed to its width
    assign cfg_ready = 1'b1;

    always_comb
    begin
        threshold_next    = threshold_reg;
        frame_length_next = frame_length_reg;
        frame_time_next   = frame_time_reg;
        gap_timeout_next  = gap_timeout_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ebcd_pkg::CFG_THRESHOLD:
                    threshold_next = cfg_data;
                ebcd_pkg::CFG_FRAME_LENGTH:
                    frame_length_next = cfg_data[ebcd_pkg::FLEN_W-1:0];
                ebcd_pkg::CFG_FRAME_TIME:
                    frame_time_next = cfg_data[ebcd_pkg::FTIME_W-1:0];
                ebcd_pkg::CFG_GAP_TIMEOUT:
                    gap_timeout_next = cfg_data[ebcd_pkg::TIMEOUT_W-1:0];
                default:
                    threshold_next = threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= ebcd_pkg::ENERGY_W'(2000000);
            frame_length_reg <= ebcd_pkg::FLEN_W'(64);
            frame_time_reg   <= ebcd_pkg::FTIME_W'(20);
            gap_timeout_reg  <= ebcd_pkg::TIMEOUT_W'(400);
        end
        else
        begin
            threshold_reg    <= threshold_next;
            frame_length_reg <= frame_length_next;
            frame_time_reg   <= frame_time_next;
            gap_timeout_reg  <= gap_timeout_next;
        end
    end

    assign back_cfg.threshold   = threshold_reg;
    assign back_cfg.frame_time  = frame_time_reg;
    assign back_cfg.gap_timeout = gap_timeout_reg;

    // Square and accumulate; hand each finished frame energy to the queue
    ebcd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample       (sample),
        .frame_length (frame_length_reg),
        .fq_full      (fq_full),
        .frame_evt    (acc_evt)
    );

    // Decouple the accumulator from the burst machine
    ebcd_frame_q u_frame_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_evt  (acc_evt),
        .q_full  (fq_full),
        .q_pop   (fq_pop),
        .out_evt (q_evt)
    );

    // Classify frames into bursts and queue the decided commands
    ebcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_evt   (q_evt),
        .frame_pop   (fq_pop),
        .cfg         (back_cfg),
        .empty       (empty),
        .pop         (pop),
        .command     (command),
        .burst_total (burst_total)
    );

endmodule

[test/tb_energy_burst_command_detector.sv]
// Self-checking testbench for the energy burst command detector.
module tb_energy_burst_command_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 12;    // pipeline drain after the last result
    localparam int ITEM_TARGET   = 550;   // samples offered over the whole run

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_GAP    = 2'd2
    } burst_phase_e;

    typedef struct {
        logic [ebcd_pkg::CFG_IDX_W-1:0] idx;
        logic [ebcd_pkg::ENERGY_W-1:0]  data;
    } reg_write_t;

    // Predicts the decided commands and holds them until the block delivers them.
    class burst_scoreboard;
        // register copies
        logic [ebcd_pkg::ENERGY_W-1:0]  threshold;
        logic [ebcd_pkg::FLEN_W-1:0]    frame_len;
        logic [ebcd_pkg::FTIME_W-1:0]   frame_step;
        logic [ebcd_pkg::TIMEOUT_W-1:0] timeout_ms;
        // detector state
        logic [ebcd_pkg::FLEN_W-1:0]    count;
        logic [ebcd_pkg::ENERGY_W-1:0]  acc;
        burst_phase_e                   ph;
        logic [ebcd_pkg::BURST_W-1:0]   bursts;
        logic [ebcd_pkg::QUIET_W-1:0]   quiet_ms;

        ebcd_pkg::result_t pending_cmds[$];
        int                mismatches;

        function new();
            threshold  = ebcd_pkg::ENERGY_W'(2000000);
            frame_len  = ebcd_pkg::FLEN_W'(64);
            frame_step = ebcd_pkg::FTIME_W'(20);
            timeout_ms = ebcd_pkg::TIMEOUT_W'(400);
            count      = '0;
            acc        = '0;
            ph         = PH_IDLE;
            bursts     = '0;
            quiet_ms   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [ebcd_pkg::CFG_IDX_W-1:0] idx,
                                logic [ebcd_pkg::ENERGY_W-1:0] data);
            case (idx)
                ebcd_pkg::CFG_THRESHOLD:    threshold  = data;
                ebcd_pkg::CFG_FRAME_LENGTH: frame_len  = data[ebcd_pkg::FLEN_W-1:0];
                ebcd_pkg::CFG_FRAME_TIME:   frame_step = data[ebcd_pkg::FTIME_W-1:0];
                ebcd_pkg::CFG_GAP_TIMEOUT:  timeout_ms = data[ebcd_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [ebcd_pkg::SAMPLE_BITS-1:0] s);
            logic [ebcd_pkg::SAMPLE_BITS-1:0] mid;
            logic [ebcd_pkg::SAMPLE_BITS-1:0] offset;
            logic [ebcd_pkg::ENERGY_W:0]      total;
            logic [ebcd_pkg::ENERGY_W-1:0]    e;
            logic [ebcd_pkg::QUIET_W:0]       q;
            logic                             loud;
            ebcd_pkg::result_t                r;
            mid    = {1'b1, {(ebcd_pkg::SAMPLE_BITS-1){1'b0}}};
            offset = (s >= mid) ? s - mid : mid - s;
            total  = {1'b0, acc} + (ebcd_pkg::ENERGY_W+1)'(offset)
                                 * (ebcd_pkg::ENERGY_W+1)'(offset);
            if (total > {1'b0, ebcd_pkg::ENERGY_MAX})
                e = ebcd_pkg::ENERGY_MAX;
            else
                e = total[ebcd_pkg::ENERGY_W-1:0];
            count = count + 1'b1;
            // still inside the frame: keep summing
            if (count != 0 && count < frame_len)
            begin
                acc = e;
                return;
            end
            count = '0;
            acc   = '0;
            loud  = e > threshold;
            case (ph)
                PH_ACTIVE:
                begin
                    if (!loud)
                    begin
                        quiet_ms = ebcd_pkg::QUIET_W'(frame_step);
                        ph       = PH_GAP;
                    end
                end
                PH_GAP:
                begin
                    if (loud)
                    begin
                        if (bursts != ebcd_pkg::BURST_MAX)
                            bursts = bursts + 1'b1;
                        ph = PH_ACTIVE;
                    end
                    else
                    begin
                        q = {1'b0, quiet_ms} + (ebcd_pkg::QUIET_W+1)'(frame_step);
                        if (q > {1'b0, ebcd_pkg::QUIET_MAX})
                            quiet_ms = ebcd_pkg::QUIET_MAX;
                        else
                            quiet_ms = q[ebcd_pkg::QUIET_W-1:0];
                        if (quiet_ms >= ebcd_pkg::QUIET_W'(timeout_ms))
                        begin
                            if (bursts != 0)
                            begin
                                case (bursts)
                                    8'd1:    r.command = ebcd_pkg::CMD_STAND;
                                    8'd2:    r.command = ebcd_pkg::CMD_SIT;
                                    8'd3:    r.command = ebcd_pkg::CMD_FORWARD;
                                    default: r.command = ebcd_pkg::CMD_BACKWARD;
                                endcase
                                r.burst_total = bursts;
                                pending_cmds.push_back(r);
                            end
                            bursts   = '0;
                            quiet_ms = '0;
                            ph       = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    // unknown codes fall back to idle
                    ph = PH_IDLE;
                    if (loud)
                    begin
                        bursts   = ebcd_pkg::BURST_W'(1);
                        quiet_ms = '0;
                        ph       = PH_ACTIVE;
                    end
                end
            endcase
        endfunction

        function void fail_note(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ERROR: %s", $realtime, msg);
        endfunction

        function void check_result(logic [ebcd_pkg::CMD_W-1:0] cmd,
                                   logic [ebcd_pkg::BURST_W-1:0] bt);
            ebcd_pkg::result_t want;
            if (pending_cmds.size() == 0)
            begin
                fail_note($sformatf("unexpected result command %0d burst_total %0d",
                                    cmd, bt));
                return;
            end
            want = pending_cmds.pop_front();
            if (want.command !== cmd)
                fail_note($sformatf("command expected %0d got %0d", want.command, cmd));
            if (want.burst_total !== bt)
                fail_note($sformatf("burst_total expected %0d got %0d",
                                    want.burst_total, bt));
        endfunction

        function int outstanding();
            return pending_cmds.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             push;
    logic                             full;
    logic [ebcd_pkg::SAMPLE_BITS-1:0] sample;
    logic                             empty;
    logic                             pop;
    logic [ebcd_pkg::CMD_W-1:0]       command;
    logic [ebcd_pkg::BURST_W-1:0]     burst_total;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [ebcd_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [ebcd_pkg::ENERGY_W-1:0]    cfg_data;

    burst_scoreboard sb;
    reg_write_t      reg_writes[$];
    int              burst_left = 0;   // samples left in the current sender burst
    int              accepted   = 0;
    bit              hold_req   = 1'b0;
    int              idle_cycles = 0;

    energy_burst_command_detector DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .empty       (empty),
        .pop         (pop),
        .command     (command),
        .burst_total (burst_total),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Samples far from the midpoint: every one squares to well over 150000.
    function automatic logic [ebcd_pkg::SAMPLE_BITS-1:0] loud_sample();
        if ($urandom_range(0, 1) == 0)
            return ebcd_pkg::SAMPLE_BITS'($urandom_range(0, 80));
        return ebcd_pkg::SAMPLE_BITS'($urandom_range(943, 1023));
    endfunction

    // Samples within 12 codes of the midpoint.
    function automatic logic [ebcd_pkg::SAMPLE_BITS-1:0] quiet_sample();
        return ebcd_pkg::SAMPLE_BITS'($urandom_range(500, 524));
    endfunction

    function automatic logic [ebcd_pkg::SAMPLE_BITS-1:0] noise_sample();
        return ebcd_pkg::SAMPLE_BITS'($urandom_range(0, 1023));
    endfunction

    // Queue a register write; bits above the register width carry junk so that
    // the masking gets exercised.
    function automatic void queue_reg(logic [ebcd_pkg::CFG_IDX_W-1:0] idx,
                                      int unsigned value);
        reg_write_t w;
        w.idx  = idx;
        w.data = ebcd_pkg::ENERGY_W'($urandom);
        case (idx)
            ebcd_pkg::CFG_FRAME_LENGTH:
                w.data[ebcd_pkg::FLEN_W-1:0] = ebcd_pkg::FLEN_W'(value);
            ebcd_pkg::CFG_FRAME_TIME:
                w.data[ebcd_pkg::FTIME_W-1:0] = ebcd_pkg::FTIME_W'(value);
            ebcd_pkg::CFG_GAP_TIMEOUT:
                w.data[ebcd_pkg::TIMEOUT_W-1:0] = ebcd_pkg::TIMEOUT_W'(value);
            default:
                w.data = ebcd_pkg::ENERGY_W'(value);
        endcase
        reg_writes.push_back(w);
    endfunction

    // Offer one sample; the sender works in bursts separated by random gaps.
    task automatic push_sample(input logic [ebcd_pkg::SAMPLE_BITS-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        // hold the sample until the block has room
        while (full) @(posedge clk);
        sb.note_sample(s);
        accepted++;
        burst_left--;
    endtask

    // Push one frame's worth of samples of the requested kind, with some noise.
    task automatic send_frame(input bit loud);
        int n;
        n = (sb.frame_len == 0) ? 1 : int'(sb.frame_len);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                push_sample(noise_sample());
            else
                push_sample(loud ? loud_sample() : quiet_sample());
        end
    endtask

    // Stop offering, wait for every predicted command, then let the pipeline
    // empty out, since the last samples may still be inside without a result.
    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Apply the queued register writes on an idle block.
    task automatic apply_reg_writes();
        reg_write_t w;
        settle();
        while (reg_writes.size() != 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.data;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(w.idx, w.data);
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: check each transfer, stall on a repeating pattern, and honor
    // a request for one long hold-off.
    initial
    begin : receiver
        int tick;
        int hold_left;
        tick      = 0;
        hold_left = 0;
        pop       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(command, burst_total);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else
            begin
                tick++;
                case ((tick / 32) % 4)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 7) != 0);
                    default: pop <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                            flen_v;
        int                            ftime_v;
        int                            gto_v;
        int                            tf;
        int                            nb;
        int                            eff;
        logic [ebcd_pkg::ENERGY_W-1:0] thr_v;

        sb        = new();
        rst_n     = 1'b0;
        push      = 1'b0;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = ebcd_pkg::CFG_THRESHOLD;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one loud frame of 64 and one quiet frame enter the gap
        // at 20 ms; a one-sample quiet frame then brings 40 ms, short of 400 ms,
        // and a lower timeout lets the next quiet frame close the sequence.
        send_frame(1'b1);
        send_frame(1'b0);
        queue_reg(ebcd_pkg::CFG_FRAME_LENGTH, 1);
        apply_reg_writes();
        push_sample(quiet_sample());
        queue_reg(ebcd_pkg::CFG_GAP_TIMEOUT, 60);
        apply_reg_writes();
        push_sample(quiet_sample());

        // Zero threshold, zero frame length (acts as one), zero frame time:
        // the gap phase cannot time out until frame time is raised.
        queue_reg(ebcd_pkg::CFG_THRESHOLD, 0);
        queue_reg(ebcd_pkg::CFG_FRAME_LENGTH, 0);
        queue_reg(ebcd_pkg::CFG_FRAME_TIME, 0);
        queue_reg(ebcd_pkg::CFG_GAP_TIMEOUT, 1);
        apply_reg_writes();
        push_sample(ebcd_pkg::SAMPLE_BITS'(512));
        push_sample(ebcd_pkg::SAMPLE_BITS'(0));
        push_sample(ebcd_pkg::SAMPLE_BITS'(511));
        push_sample(ebcd_pkg::SAMPLE_BITS'(512));
        push_sample(ebcd_pkg::SAMPLE_BITS'(1023));
        push_sample(ebcd_pkg::SAMPLE_BITS'(512));
        push_sample(ebcd_pkg::SAMPLE_BITS'(512));
        queue_reg(ebcd_pkg::CFG_FRAME_TIME, 1);
        apply_reg_writes();
        push_sample(ebcd_pkg::SAMPLE_BITS'(512));

        // Largest threshold: nothing counts as sound. Then zero gap timeout,
        // so the second quiet frame always decides.
        queue_reg(ebcd_pkg::CFG_THRESHOLD, 32'h3FF_FFFF);
        queue_reg(ebcd_pkg::CFG_GAP_TIMEOUT, 0);
        apply_reg_writes();
        push_sample(ebcd_pkg::SAMPLE_BITS'(0));
        push_sample(ebcd_pkg::SAMPLE_BITS'(1023));
        queue_reg(ebcd_pkg::CFG_THRESHOLD, 100);
        apply_reg_writes();
        push_sample(ebcd_pkg::SAMPLE_BITS'(0));
        push_sample(ebcd_pkg::SAMPLE_BITS'(512));
        push_sample(ebcd_pkg::SAMPLE_BITS'(512));
        repeat (3)
        begin
            push_sample(ebcd_pkg::SAMPLE_BITS'(0));
            push_sample(ebcd_pkg::SAMPLE_BITS'(512));
        end
        push_sample(ebcd_pkg::SAMPLE_BITS'(512));

        // Lower the frame length mid-frame: the partial frame closes on the
        // very next sample.
        queue_reg(ebcd_pkg::CFG_THRESHOLD, 1000000);
        queue_reg(ebcd_pkg::CFG_FRAME_LENGTH, 16);
        queue_reg(ebcd_pkg::CFG_FRAME_TIME, 1000);
        queue_reg(ebcd_pkg::CFG_GAP_TIMEOUT, 1000);
        apply_reg_writes();
        repeat (16) push_sample(loud_sample());
        repeat (6) push_sample(quiet_sample());
        queue_reg(ebcd_pkg::CFG_FRAME_LENGTH, 1);
        apply_reg_writes();
        repeat (3) push_sample(quiet_sample());

        // Back pressure: dense results while the receiver holds off, so the
        // result and frame queues fill and the block stops taking samples.
        queue_reg(ebcd_pkg::CFG_THRESHOLD, 1000);
        queue_reg(ebcd_pkg::CFG_FRAME_TIME, 1);
        queue_reg(ebcd_pkg::CFG_GAP_TIMEOUT, 0);
        apply_reg_writes();
        hold_req = 1'b1;
        repeat (25)
        begin
            nb = $urandom_range(1, 3);
            repeat (nb)
            begin
                push_sample(loud_sample());
                push_sample(quiet_sample());
            end
            push_sample(quiet_sample());
        end

        // Random part: well-formed burst sequences under random settings,
        // with noisy samples and stray samples that shift the frame alignment.
        while (accepted < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                7, 8:    flen_v = $urandom_range(4, 10);
                9:       flen_v = 0;
                default: flen_v = $urandom_range(1, 3);
            endcase
            eff     = (flen_v == 0) ? 1 : flen_v;
            ftime_v = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023)
                                                  : $urandom_range(1, 40);
            gto_v   = ftime_v * $urandom_range(0, 4) + $urandom_range(0, ftime_v - 1);
            if ($urandom_range(0, 7) == 0)
                thr_v = ebcd_pkg::ENERGY_W'($urandom);
            else
                thr_v = ebcd_pkg::ENERGY_W'(eff * $urandom_range(1000, 150000));
            queue_reg(ebcd_pkg::CFG_THRESHOLD, thr_v);
            queue_reg(ebcd_pkg::CFG_FRAME_LENGTH, flen_v);
            queue_reg(ebcd_pkg::CFG_FRAME_TIME, ftime_v);
            queue_reg(ebcd_pkg::CFG_GAP_TIMEOUT, gto_v);
            apply_reg_writes();

            // quiet frames from entering the gap to the decision
            tf = (gto_v + ftime_v - 1) / ftime_v;
            if (tf < 2)
                tf = 2;
            repeat ($urandom_range(1, 3))
            begin
                nb = $urandom_range(1, 6);
                for (int b = 1; b <= nb; b++)
                begin
                    repeat ($urandom_range(1, 2)) send_frame(1'b1);
                    if (b < nb)
                        repeat ($urandom_range(1, tf - 1)) send_frame(1'b0);
                    if ($urandom_range(0, 19) == 0)
                        push_sample(noise_sample());
                end
                repeat (tf + $urandom_range(0, 1)) send_frame(1'b0);
            end
        end

        settle();
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
